>>> rtl/mecc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecc_pkg
// Shared constants, result codes and the structures that pass between the
// table parser and the result stage of the enabled-CPU collector.
// ----------------------------------------------------------------------------
package mecc_pkg;

    // Table layout.
    localparam int HEADER_BYTES     = 44;
    localparam int ADDR_OFFSET      = 36;
    localparam int MIN_ENTRY        = 2;
    localparam int CPU_ENTRY_BYTES  = 8;

    // A table never reports more than this many processors.
    localparam int MAX_IDS          = 16;
    localparam int ID_AW            = 4;
    localparam int ID_CW            = 5;
    localparam int CPU_CAPACITY_DEF = 16;

    // Width of the packed result word (49 payload bits, padded to bytes).
    localparam int M_DATA_W         = 56;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_BAD_LENGTH   = 3'd1,
        ST_BAD_CHECKSUM = 3'd2,
        ST_READ_ERROR   = 3'd3,
        ST_NO_CPUS      = 3'd4
    } status_t;

    // Write of one collected id into the id memory.
    typedef struct packed {
        logic             en;
        logic [ID_AW-1:0] addr;
        logic [7:0]       id;
    } id_wr_t;

    // The table has ended with this outcome.
    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [ID_CW-1:0] count;
        logic [31:0]      address;
    } table_end_t;

endpackage

>>> rtl/mecc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mecc_parser
// Byte-at-a-time parser: tracks offset, length, checksum and controller
// address, walks the entry list and issues id writes and the end-of-table event.
// ----------------------------------------------------------------------------
module mecc_parser import mecc_pkg::*; #(
    parameter int CPU_CAPACITY = CPU_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_accept,
    input  logic [7:0] data_byte,
    input  logic       start_of_table,
    input  logic       fetch_failed,
    output id_wr_t     id_wr,
    output table_end_t table_end
);

    localparam int STORE_LIMIT = (CPU_CAPACITY < MAX_IDS) ? CPU_CAPACITY : MAX_IDS;
    localparam logic [ID_CW-1:0] LIMIT = ID_CW'(STORE_LIMIT);

    // Parse state.
    logic        active_reg, active_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] length_reg, length_next;
    logic [7:0]  sum_reg, sum_next;
    logic [31:0] lapic_reg, lapic_next;
    logic [31:0] entry_start_reg, entry_start_next;
    logic [7:0]  entry_type_reg, entry_type_next;
    logic [7:0]  entry_len_reg, entry_len_next;
    logic [7:0]  entry_id_reg, entry_id_next;
    logic        stopped_reg, stopped_next;
    logic [ID_CW-1:0] total_reg, total_next;

    // State as seen by this byte, after a start of table has cleared it.
    logic        cur_active;
    logic [31:0] cur_offset;
    logic [31:0] cur_length;
    logic [7:0]  cur_sum;
    logic [31:0] cur_lapic;
    logic [31:0] cur_entry_start;
    logic [7:0]  cur_entry_type;
    logic [7:0]  cur_entry_len;
    logic [7:0]  cur_entry_id;
    logic        cur_stopped;
    logic [ID_CW-1:0] cur_total;

    // Working values.
    logic [31:0] rel;
    logic        in_walk;
    logic [32:0] need;

    always_comb begin
        cur_active      = start_of_table | active_reg;
        cur_offset      = start_of_table ? 32'd0 : offset_reg;
        cur_length      = start_of_table ? 32'd0 : length_reg;
        cur_sum         = start_of_table ? 8'd0 : sum_reg;
        cur_lapic       = start_of_table ? 32'd0 : lapic_reg;
        cur_entry_start = start_of_table ? 32'(HEADER_BYTES) : entry_start_reg;
        cur_entry_type  = start_of_table ? 8'd0 : entry_type_reg;
        cur_entry_len   = start_of_table ? 8'd0 : entry_len_reg;
        cur_entry_id    = start_of_table ? 8'd0 : entry_id_reg;
        cur_stopped     = start_of_table ? 1'b0 : stopped_reg;
        cur_total       = start_of_table ? '0 : total_reg;
    end

    // Next-state logic for one accepted byte.
    always_comb begin
        active_next      = active_reg;
        offset_next      = offset_reg;
        length_next      = length_reg;
        sum_next         = sum_reg;
        lapic_next       = lapic_reg;
        entry_start_next = entry_start_reg;
        entry_type_next  = entry_type_reg;
        entry_len_next   = entry_len_reg;
        entry_id_next    = entry_id_reg;
        stopped_next     = stopped_reg;
        total_next       = total_reg;
        id_wr            = '0;
        table_end        = '0;
        table_end.status = ST_OK;
        rel              = '0;
        in_walk          = 1'b0;
        need             = '0;

        if (byte_accept && cur_active) begin
            active_next      = 1'b1;
            offset_next      = cur_offset;
            length_next      = cur_length;
            sum_next         = cur_sum;
            lapic_next       = cur_lapic;
            entry_start_next = cur_entry_start;
            entry_type_next  = cur_entry_type;
            entry_len_next   = cur_entry_len;
            entry_id_next    = cur_entry_id;
            stopped_next     = cur_stopped;
            total_next       = cur_total;

            if (fetch_failed) begin
                // Unreadable byte ends the table at once.
                active_next       = 1'b0;
                table_end.valid   = 1'b1;
                table_end.status  = ST_READ_ERROR;
                table_end.address = cur_lapic;
            end else begin
                sum_next = cur_sum + data_byte;

                // Little-endian header fields.
                if (cur_offset[31:2] == 30'd1) begin
                    unique case (cur_offset[1:0])
                        2'd0: length_next[7:0]   = data_byte;
                        2'd1: length_next[15:8]  = data_byte;
                        2'd2: length_next[23:16] = data_byte;
                        default: length_next[31:24] = data_byte;
                    endcase
                end
                if (cur_offset[31:2] == 30'(ADDR_OFFSET / 4)) begin
                    unique case (cur_offset[1:0])
                        2'd0: lapic_next[7:0]   = data_byte;
                        2'd1: lapic_next[15:8]  = data_byte;
                        2'd2: lapic_next[23:16] = data_byte;
                        default: lapic_next[31:24] = data_byte;
                    endcase
                end

                if (cur_offset == 32'd7 && length_next < 32'(HEADER_BYTES)) begin
                    // Length too short to hold the header.
                    active_next       = 1'b0;
                    table_end.valid   = 1'b1;
                    table_end.status  = ST_BAD_LENGTH;
                    table_end.address = lapic_next;
                end else begin
                    // Entry walk.
                    in_walk = (cur_offset >= 32'(HEADER_BYTES)) && !cur_stopped &&
                              (cur_offset >= cur_entry_start);
                    if (in_walk) begin
                        rel = cur_offset - cur_entry_start;
                        if (rel >= 32'(MIN_ENTRY) && rel == {24'd0, cur_entry_len}) begin
                            entry_start_next = cur_offset;
                            rel              = '0;
                        end
                        need = {1'b0, cur_offset} + 33'(MIN_ENTRY);
                        priority if (rel == 32'd0) begin
                            if (need > {1'b0, length_next} || cur_total >= LIMIT) begin
                                stopped_next = 1'b1;
                            end else begin
                                entry_type_next = data_byte;
                                entry_len_next  = 8'd0;
                                entry_id_next   = 8'd0;
                            end
                        end else if (rel == 32'd1) begin
                            entry_len_next = data_byte;
                            if (data_byte < 8'(MIN_ENTRY)) begin
                                stopped_next = 1'b1;
                            end
                        end else if (rel == 32'd3) begin
                            entry_id_next = data_byte;
                        end else if (rel == 32'd4) begin
                            // Flags byte: store the id of an enabled processor.
                            if (cur_entry_type == 8'd0 &&
                                cur_entry_len >= 8'(CPU_ENTRY_BYTES) &&
                                data_byte[0] && cur_total < LIMIT) begin
                                id_wr.en   = 1'b1;
                                id_wr.addr = ID_AW'(cur_total);
                                id_wr.id   = cur_entry_id;
                                total_next = cur_total + 1'b1;
                            end
                        end else begin
                            entry_id_next = cur_entry_id;
                        end
                    end

                    // Final byte of the table.
                    if (cur_offset >= 32'd7 &&
                        ({1'b0, cur_offset} + 33'd1) == {1'b0, length_next}) begin
                        active_next       = 1'b0;
                        table_end.valid   = 1'b1;
                        table_end.address = lapic_next;
                        if (sum_next != 8'd0) begin
                            table_end.status = ST_BAD_CHECKSUM;
                        end else if (total_next == '0) begin
                            table_end.status = ST_NO_CPUS;
                        end else begin
                            table_end.status = ST_OK;
                            table_end.count  = total_next;
                        end
                    end else begin
                        offset_next = cur_offset + 32'd1;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= 1'b0;
            offset_reg      <= '0;
            length_reg      <= '0;
            sum_reg         <= '0;
            lapic_reg       <= '0;
            entry_start_reg <= 32'(HEADER_BYTES);
            entry_type_reg  <= '0;
            entry_len_reg   <= '0;
            entry_id_reg    <= '0;
            stopped_reg     <= 1'b0;
            total_reg       <= '0;
        end else begin
            active_reg      <= active_next;
            offset_reg      <= offset_next;
            length_reg      <= length_next;
            sum_reg         <= sum_next;
            lapic_reg       <= lapic_next;
            entry_start_reg <= entry_start_next;
            entry_type_reg  <= entry_type_next;
            entry_len_reg   <= entry_len_next;
            entry_id_reg    <= entry_id_next;
            stopped_reg     <= stopped_next;
            total_reg       <= total_next;
        end
    end

endmodule

>>> rtl/madt_enabled_cpu_collector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_enabled_cpu_collector
// Parses one interrupt-controller table per run of bytes and reports the ids
// of its enabled processors, or one error word.
//
// Input: one byte per cycle while the parser runs; the final (or failing) byte
// of a table holds s_tready low until all its result words are issued (one
// id-memory read per cycle while the read stage can move). Result words pass
// the job, read and output registers, one per cycle while m_tready is high.
// Reset: synchronous, active-low aresetn clears all control and parse state;
// the id memory is not cleared (only written entries are ever read).
// ----------------------------------------------------------------------------
module madt_enabled_cpu_collector import mecc_pkg::*; #(
    parameter int CPU_CAPACITY = CPU_CAPACITY_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input words.
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] data_byte
    input  logic [1:0]          s_tuser,   // [0] start_of_table, [1] fetch_failed
    // Result words.
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [7:0] apic_id, [11:8] cpu_index,
                                           // [16:12] cpu_count,
                                           // [48:17] controller_address
    output logic [2:0]          m_tuser,   // [2:0] status
    output logic                m_tlast
);

    localparam int STORE_DEPTH = (CPU_CAPACITY < MAX_IDS) ? CPU_CAPACITY : MAX_IDS;
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    id_wr_t     id_wr;
    table_end_t table_end;
    logic       byte_accept;

    assign byte_accept = s_tvalid && s_tready;

    mecc_parser #(
        .CPU_CAPACITY (CPU_CAPACITY)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .byte_accept    (byte_accept),
        .data_byte      (s_tdata),
        .start_of_table (s_tuser[0]),
        .fetch_failed   (s_tuser[1]),
        .id_wr          (id_wr),
        .table_end      (table_end)
    );

    // Id memory.
    logic [7:0] id_mem [STORE_DEPTH];
    logic [7:0] mem_q_reg;

    // Result job, read stage and output register.
    logic             job_busy_reg;
    logic             job_single_reg;
    status_t          job_status_reg;
    logic [ID_CW-1:0] job_cnt_reg;
    logic [IDX_W-1:0] job_idx_reg;
    logic [31:0]      job_addr_reg;

    logic             stg_vld_reg;
    logic             stg_single_reg;
    status_t          stg_status_reg;
    logic [ID_CW-1:0] stg_cnt_reg;
    logic [IDX_W-1:0] stg_idx_reg;
    logic [31:0]      stg_addr_reg;
    logic             stg_last_reg;

    logic             out_vld_reg;
    logic [7:0]       out_id_reg;
    logic [3:0]       out_idx_reg;
    logic [ID_CW-1:0] out_cnt_reg;
    logic [31:0]      out_addr_reg;
    status_t          out_status_reg;
    logic             out_last_reg;

    logic out_free;
    logic issue;
    logic job_last;

    assign out_free = !out_vld_reg || m_tready;
    assign issue    = job_busy_reg && (!stg_vld_reg || out_free);
    assign job_last = job_single_reg || ((ID_CW'(job_idx_reg) + 1'b1) == job_cnt_reg);
    assign s_tready = !job_busy_reg;

    // Memory write port and registered read port.
    always_ff @(posedge aclk) begin
        if (id_wr.en) begin
            id_mem[id_wr.addr[IDX_W-1:0]] <= id_wr.id;
        end
        if (issue && !job_single_reg) begin
            mem_q_reg <= id_mem[job_idx_reg];
        end
    end

    // Job sequencer: one read (or one error word) per cycle while the read stage can move.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_busy_reg   <= 1'b0;
            job_single_reg <= 1'b0;
            job_status_reg <= ST_OK;
            job_cnt_reg    <= '0;
            job_idx_reg    <= '0;
            job_addr_reg   <= '0;
        end else if (table_end.valid) begin
            job_busy_reg   <= 1'b1;
            job_single_reg <= (table_end.status != ST_OK);
            job_status_reg <= table_end.status;
            job_cnt_reg    <= table_end.count;
            job_idx_reg    <= '0;
            job_addr_reg   <= table_end.address;
        end else if (issue) begin
            job_idx_reg <= job_idx_reg + 1'b1;
            if (job_last) begin
                job_busy_reg <= 1'b0;
            end
        end
    end

    // Read stage, holds a word until the output register can take it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg    <= 1'b0;
            stg_single_reg <= 1'b0;
            stg_status_reg <= ST_OK;
            stg_cnt_reg    <= '0;
            stg_idx_reg    <= '0;
            stg_addr_reg   <= '0;
            stg_last_reg   <= 1'b0;
        end else if (issue) begin
            stg_vld_reg    <= 1'b1;
            stg_single_reg <= job_single_reg;
            stg_status_reg <= job_status_reg;
            stg_cnt_reg    <= job_single_reg ? '0 : job_cnt_reg;
            stg_idx_reg    <= job_single_reg ? '0 : job_idx_reg;
            stg_addr_reg   <= job_addr_reg;
            stg_last_reg   <= job_last;
        end else if (out_free) begin
            stg_vld_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg    <= 1'b0;
            out_id_reg     <= '0;
            out_idx_reg    <= '0;
            out_cnt_reg    <= '0;
            out_addr_reg   <= '0;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= stg_vld_reg;
            if (stg_vld_reg) begin
                out_id_reg     <= stg_single_reg ? 8'd0 : mem_q_reg;
                out_idx_reg    <= 4'(stg_idx_reg);
                out_cnt_reg    <= stg_cnt_reg;
                out_addr_reg   <= stg_addr_reg;
                out_status_reg <= stg_status_reg;
                out_last_reg   <= stg_last_reg;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_addr_reg, out_cnt_reg, out_idx_reg, out_id_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> verif/madt_enabled_cpu_collector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_enabled_cpu_collector_tb
// Streams interrupt-controller tables into the collector one byte per word
// and checks every result word against a predictor that parses the same
// bytes. Directed tables cover the error paths and the entry-walk corners,
// then random tables and broken sequences run with random gaps and stalls
// on both streams.
// ----------------------------------------------------------------------------
module madt_enabled_cpu_collector_tb import mecc_pkg::*;;

    // Ids kept per table: the smaller of the store capacity and 16.
    localparam int ID_LIMIT = (CPU_CAPACITY_DEF < MAX_IDS) ? CPU_CAPACITY_DEF : MAX_IDS;

    // One expected result word.
    typedef struct {
        logic [7:0]  apic_id;
        logic [3:0]  cpu_index;
        logic [4:0]  cpu_count;
        logic [31:0] address;
        status_t     status;
        logic        last;
    } cpu_word_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata  = 8'h00;   // [7:0] data_byte
    logic [1:0]          s_tuser  = 2'b00;   // [0] start_of_table, [1] fetch_failed
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;            // [7:0] apic_id, [11:8] cpu_index,
                                             // [16:12] cpu_count,
                                             // [48:17] controller_address
    logic [2:0]          m_tuser;            // [2:0] status
    logic                m_tlast;

    cpu_word_t  pending_words[$];
    logic [7:0] tbl[$];
    int         mismatches      = 0;
    int         bytes_sent      = 0;
    int         words_predicted = 0;
    int         words_checked   = 0;
    int         stall_left      = 0;
    bit         idle_on         = 1'b1;

    // Predictor copy of the parse state.
    int unsigned p_offset;
    logic [31:0] p_length;
    logic [7:0]  p_sum;
    logic [31:0] p_address;
    int unsigned p_entry_start;
    logic [7:0]  p_type;
    logic [7:0]  p_elen;
    logic [7:0]  p_id;
    logic        p_enabled;
    logic        p_walk_done;
    logic        p_active;
    logic [7:0]  p_ids[MAX_IDS];
    int          p_count;

    madt_enabled_cpu_collector uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Mismatch reporting.
    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: result word %0d: %s expected 0x%0h, got 0x%0h",
                 $time, words_checked, what, want, got);
        mismatches++;
    endtask

    // Compare one accepted result word with the oldest expectation.
    task automatic check_word();
        cpu_word_t want;
        if (pending_words.size() == 0) begin
            report_mismatch("unexpected word, tdata", 64'd0, 64'(m_tdata));
            return;
        end
        want = pending_words.pop_front();
        if (m_tdata[7:0] !== want.apic_id)
            report_mismatch("apic_id", 64'(want.apic_id), 64'(m_tdata[7:0]));
        if (m_tdata[11:8] !== want.cpu_index)
            report_mismatch("cpu_index", 64'(want.cpu_index), 64'(m_tdata[11:8]));
        if (m_tdata[16:12] !== want.cpu_count)
            report_mismatch("cpu_count", 64'(want.cpu_count), 64'(m_tdata[16:12]));
        if (m_tdata[48:17] !== want.address)
            report_mismatch("controller_address", 64'(want.address), 64'(m_tdata[48:17]));
        if (m_tdata[M_DATA_W-1:49] !== '0)
            report_mismatch("tdata padding", 64'd0, 64'(m_tdata[M_DATA_W-1:49]));
        if (m_tuser !== want.status)
            report_mismatch("status", 64'(want.status), 64'(m_tuser));
        if (m_tlast !== want.last)
            report_mismatch("last", 64'(want.last), 64'(m_tlast));
        words_checked++;
    endtask

    // Result side: check accepted words, then stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            check_word();
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        p_offset      = 0;
        p_length      = '0;
        p_sum         = '0;
        p_address     = '0;
        p_entry_start = HEADER_BYTES;
        p_type        = '0;
        p_elen        = '0;
        p_id          = '0;
        p_enabled     = 1'b0;
        p_walk_done   = 1'b0;
        p_count       = 0;
        foreach (p_ids[i]) p_ids[i] = '0;
    endfunction

    function automatic void expect_word(input logic [7:0] id, input logic [3:0] idx,
                                        input logic [4:0] cnt, input status_t st,
                                        input logic last);
        cpu_word_t w;
        w.apic_id   = id;
        w.cpu_index = idx;
        w.cpu_count = cnt;
        w.address   = p_address;
        w.status    = st;
        w.last      = last;
        pending_words.push_back(w);
        words_predicted++;
    endfunction

    // Entry walk for one byte at or past the header.
    function automatic void walk_entry_byte(input int unsigned off, input logic [7:0] b);
        int unsigned rel;
        if (p_walk_done || off < p_entry_start)
            return;
        rel = off - p_entry_start;
        // The current entry has ended: this byte opens the next one.
        if (rel >= MIN_ENTRY && rel == 32'(p_elen)) begin
            p_entry_start = off;
            rel = 0;
        end
        if (rel == 0) begin
            if (64'(off) + MIN_ENTRY > 64'(p_length) || p_count >= ID_LIMIT) begin
                p_walk_done = 1'b1;
                return;
            end
            p_type    = b;
            p_elen    = '0;
            p_id      = '0;
            p_enabled = 1'b0;
        end else if (rel == 1) begin
            p_elen = b;
            if (b < MIN_ENTRY)
                p_walk_done = 1'b1;
        end else if (rel == 3) begin
            p_id = b;
        end else if (rel == 4) begin
            p_enabled = b[0];
            if (p_type == 8'd0 && p_elen >= CPU_ENTRY_BYTES && p_enabled &&
                p_count < ID_LIMIT) begin
                p_ids[p_count] = p_id;
                p_count++;
            end
        end
    endfunction

    // Expected results for one accepted input word.
    function automatic void predict_byte(input logic [7:0] b, input logic start,
                                         input logic failed);
        int unsigned off;
        int          n;
        if (start) begin
            clear_parse();
            p_active = 1'b1;
        end
        if (!p_active)
            return;
        if (failed) begin
            expect_word(8'd0, 4'd0, 5'd0, ST_READ_ERROR, 1'b1);
            p_active = 1'b0;
            return;
        end
        off   = p_offset;
        p_sum = p_sum + b;
        if (off >= 4 && off <= 7)
            p_length |= 32'(b) << (8 * (off - 4));
        if (off >= ADDR_OFFSET && off <= ADDR_OFFSET + 3)
            p_address |= 32'(b) << (8 * (off - ADDR_OFFSET));
        if (off == 7 && p_length < HEADER_BYTES) begin
            expect_word(8'd0, 4'd0, 5'd0, ST_BAD_LENGTH, 1'b1);
            p_active = 1'b0;
            return;
        end
        if (off >= HEADER_BYTES)
            walk_entry_byte(off, b);
        // Final byte of the table: checksum first, then the id list.
        if (off >= 7 && 64'(off) + 1 == 64'(p_length)) begin
            p_active = 1'b0;
            if (p_sum != 8'd0) begin
                expect_word(8'd0, 4'd0, 5'd0, ST_BAD_CHECKSUM, 1'b1);
            end else if (p_count == 0) begin
                expect_word(8'd0, 4'd0, 5'd0, ST_NO_CPUS, 1'b1);
            end else begin
                n = p_count;
                for (int k = 0; k < n; k++)
                    expect_word(p_ids[k], 4'(k), 5'(n), ST_OK, k == n - 1);
            end
            return;
        end
        p_offset = off + 1;
    endfunction

    // ------------------------------------------------------------------
    // Table building
    // ------------------------------------------------------------------
    function automatic void start_table(input logic [31:0] addr);
        tbl.delete();
        for (int i = 0; i < HEADER_BYTES; i++)
            tbl.push_back(8'($urandom));
        {tbl[ADDR_OFFSET + 3], tbl[ADDR_OFFSET + 2],
         tbl[ADDR_OFFSET + 1], tbl[ADDR_OFFSET]} = addr;
    endfunction

    // Lengths below the minimum still take two bytes: type and length.
    function automatic void add_entry(input logic [7:0] etype, input logic [7:0] elen,
                                      input logic [7:0] id, input logic [7:0] flags);
        int span;
        span = (elen < MIN_ENTRY) ? MIN_ENTRY : int'(elen);
        for (int i = 0; i < span; i++) begin
            case (i)
                0:       tbl.push_back(etype);
                1:       tbl.push_back(elen);
                3:       tbl.push_back(id);
                4:       tbl.push_back(flags);
                default: tbl.push_back(8'($urandom));
            endcase
        end
    endfunction

    function automatic void add_cpu(input logic [7:0] id, input logic enabled);
        add_entry(8'd0, 8'(CPU_ENTRY_BYTES), id, {7'($urandom), enabled});
    endfunction

    // Write the length field and balance the sum over the first len bytes
    // through byte 9; a bad sum gets a nonzero offset there.
    function automatic void close_table(input logic [31:0] len, input bit bad_sum);
        logic [7:0] sum;
        {tbl[7], tbl[6], tbl[5], tbl[4]} = len;
        tbl[9] = 8'd0;
        sum    = 8'd0;
        for (int unsigned i = 0; i < len && i < tbl.size(); i++)
            sum += tbl[i];
        tbl[9] = -sum;
        if (bad_sum)
            tbl[9] = tbl[9] + 8'($urandom_range(1, 255));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic start, input logic failed);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {failed, start};
        do @(posedge aclk); while (!s_tready);
        predict_byte(b, start, failed);
        bytes_sent++;
    endtask

    task automatic send_table(input int n);
        for (int i = 0; i < n; i++)
            send_byte(tbl[i], i == 0, 1'b0);
    endtask

    // Random table with a mix of entry kinds; returns its full length.
    function automatic int build_random_table();
        int          n_entries;
        int          kind;
        logic [31:0] addr;
        case ($urandom_range(0, 3))
            0:       addr = '0;
            1:       addr = '1;
            default: addr = $urandom;
        endcase
        n_entries = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                : $urandom_range(0, 6);
        start_table(addr);
        repeat (n_entries) begin
            kind = $urandom_range(0, 19);
            if (kind < 10)
                add_cpu(8'($urandom), 1'b1);
            else if (kind < 12)
                add_cpu(8'($urandom), 1'b0);
            else if (kind < 14)
                add_entry(8'd0, 8'($urandom_range(2, 7)), 8'($urandom), 8'h01);
            else if (kind < 16)
                add_entry(8'd0, 8'($urandom_range(9, 20)), 8'($urandom), 8'($urandom));
            else if (kind < 19)
                add_entry(8'($urandom_range(1, 255)), 8'($urandom_range(2, 16)),
                          8'($urandom), 8'($urandom));
            else
                add_entry(8'($urandom), 8'($urandom_range(0, 1)), 8'd0, 8'd0);
        end
        close_table(tbl.size(), $urandom_range(0, 9) == 0);
        return tbl.size();
    endfunction

    task automatic run_random_table();
        int len;
        len = build_random_table();
        // Sometimes cut the table short so late entries fall past its end.
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(HEADER_BYTES, len);
            close_table(len, $urandom_range(0, 9) == 0);
        end
        send_table(len);
    endtask

    // Broken sequences: stray bytes, bad length, read error, restart, huge length.
    task automatic run_broken_table();
        int len;
        int n;
        len = build_random_table();
        case ($urandom_range(0, 4))
            0: repeat ($urandom_range(1, 3))
                   send_byte(8'($urandom), 1'b0, 1'($urandom));
            1: begin
                close_table($urandom_range(0, HEADER_BYTES - 1), 1'b0);
                send_table(8);
            end
            2: begin
                n = $urandom_range(0, len - 1);
                if (n == 0) begin
                    send_byte(tbl[0], 1'b1, 1'b1);
                end else begin
                    send_table(n);
                    send_byte(8'($urandom), 1'b0, 1'b1);
                end
            end
            3: send_table($urandom_range(1, len - 1));
            default: begin
                close_table($urandom_range(len + 1, 32'hFFFF_FFFF), 1'b0);
                send_table(len);
                send_byte(8'($urandom), 1'b0, 1'b1);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes with no table open, including failed fetches, give nothing.
    task automatic test_idle_bytes();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b0);
    endtask

    // Length field below the header size ends the table at byte 7.
    task automatic test_bad_length();
        start_table($urandom);
        close_table(32'd0, 1'b0);
        send_table(8);
        start_table($urandom);
        close_table(HEADER_BYTES - 1, 1'b0);
        send_table(8);
    endtask

    // Failed fetch on the first byte and in the middle of the entries.
    task automatic test_read_error();
        send_byte(8'hFF, 1'b1, 1'b1);
        start_table(32'hFEE0_0000);
        add_cpu(8'h11, 1'b1);
        add_cpu(8'h22, 1'b1);
        close_table(tbl.size(), 1'b0);
        send_table(HEADER_BYTES + 5);
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    // Mixed entry kinds: only long enough, enabled type-0 entries count.
    task automatic test_cpu_list();
        start_table(32'hFFFF_FFFF);
        add_cpu(8'h00, 1'b1);
        add_cpu(8'hFF, 1'b1);
        add_cpu(8'h33, 1'b0);
        add_entry(8'd0, 8'd6, 8'h44, 8'hFF);
        add_entry(8'd0, 8'd7, 8'h45, 8'hFF);
        add_entry(8'd1, 8'd12, 8'h55, 8'hFF);
        add_entry(8'd2, 8'd10, 8'h66, 8'hFF);
        add_entry(8'd0, 8'd20, 8'h77, 8'h01);
        add_cpu(8'h5A, 1'b1);
        close_table(tbl.size(), 1'b0);
        send_table(tbl.size());
    endtask

    // A bad sum wins over collected ids.
    task automatic test_bad_checksum();
        start_table(32'h1234_5678);
        add_cpu(8'h01, 1'b1);
        add_cpu(8'h02, 1'b1);
        close_table(tbl.size(), 1'b1);
        send_table(tbl.size());
    endtask

    // Header-only table and one with no enabled processor.
    task automatic test_no_cpus();
        start_table(32'h0000_0000);
        close_table(HEADER_BYTES, 1'b0);
        send_table(HEADER_BYTES);
        start_table($urandom);
        add_cpu(8'h10, 1'b0);
        add_entry(8'd1, 8'd12, 8'h00, 8'h01);
        close_table(tbl.size(), 1'b0);
        send_table(tbl.size());
    endtask

    // An entry of length 0 or 1 ends the walk for good.
    task automatic test_walk_stop();
        for (int elen = 0; elen < MIN_ENTRY; elen++) begin
            start_table($urandom);
            add_cpu(8'h80, 1'b1);
            add_entry(8'd0, 8'(elen), 8'd0, 8'd0);
            add_cpu(8'h81, 1'b1);
            close_table(tbl.size(), 1'b0);
            send_table(tbl.size());
        end
    endtask

    // Table ends inside the second entry: before its flags byte, right on
    // it, and one byte after the first entry.
    task automatic test_entry_past_end();
        int cut[3];
        cut = '{HEADER_BYTES + CPU_ENTRY_BYTES + 4, HEADER_BYTES + CPU_ENTRY_BYTES + 5,
                HEADER_BYTES + CPU_ENTRY_BYTES + 1};
        foreach (cut[i]) begin
            start_table($urandom);
            add_cpu(8'hA0, 1'b1);
            add_cpu(8'hA1, 1'b1);
            close_table(cut[i], 1'b0);
            send_table(cut[i]);
        end
    endtask

    // More enabled processors than the store keeps.
    task automatic test_store_full();
        start_table($urandom);
        for (int i = 0; i < ID_LIMIT + 2; i++)
            add_cpu(8'(i * 13 + 7), 1'b1);
        close_table(tbl.size(), 1'b0);
        send_table(tbl.size());
    endtask

    // A new start in the middle of a table drops the old one silently.
    task automatic test_restart();
        void'(build_random_table());
        send_table(30);
        start_table(32'hCAFE_F00D);
        add_cpu(8'h42, 1'b1);
        close_table(tbl.size(), 1'b0);
        send_table(tbl.size());
    endtask

    // Largest length field: the table only ends through a failed fetch.
    task automatic test_huge_length();
        start_table($urandom);
        add_cpu(8'h99, 1'b1);
        close_table(32'hFFFF_FFFF, 1'b0);
        send_table(tbl.size());
        send_byte(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_random_tables();
        int first_bytes;
        int first_words;
        first_bytes = bytes_sent;
        first_words = words_predicted;
        while (bytes_sent - first_bytes < 330 || words_predicted - first_words < 40) begin
            if ($urandom_range(0, 4) == 0)
                run_broken_table();
            else
                run_random_table();
        end
    endtask

    // Last stretch at full rate on both streams.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (3) run_random_table();
    endtask

    task automatic wait_for_results();
        int guard;
        guard = 0;
        while (pending_words.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
    endtask

    initial begin
        p_active = 1'b0;
        clear_parse();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_bytes();
        test_bad_length();
        test_read_error();
        test_cpu_list();
        test_bad_checksum();
        test_no_cpus();
        test_walk_stop();
        test_entry_past_end();
        test_store_full();
        test_restart();
        test_huge_length();
        test_random_tables();
        test_full_rate();

        s_tvalid <= 1'b0;
        wait_for_results();
        if (pending_words.size() != 0)
            report_mismatch("words never delivered", 64'(pending_words.size()), 64'd0);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Run limit.
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
